[rtl/core/mlfh_pkg.sv]
// Shared types and constants of the motor link frame handler.
// Depends on nothing; every file of the block but mlfh_stream_if imports it.
package mlfh_pkg;

	// Framing of the link.
	localparam int          FRAME_BYTES = 7;
	localparam int          BODY_BYTES  = FRAME_BYTES - 2;
	localparam int          POS_W       = $clog2(FRAME_BYTES);
	localparam logic [7:0]  SYNC_BYTE   = 8'h5C;
	localparam logic [7:0]  TX_HEAD     = 8'hAA;
	localparam logic [7:0]  TX_TAIL     = 8'h55;
	localparam logic [3:0]  NIBBLE_SET  = 4'hF;

	// Result kinds.
	localparam logic [1:0]  KIND_SPEED    = 2'd0;
	localparam logic [1:0]  KIND_CSUM_ERR = 2'd1;
	localparam logic [1:0]  KIND_TX       = 2'd2;

	// Request type codes.
	localparam logic        REQ_RX_BYTE = 1'b0;
	localparam logic        REQ_COMMAND = 1'b1;

	// Index of a result within one job: 0 is the report, then the command bytes.
	localparam int          STEP_W      = $clog2(FRAME_BYTES + 1);

	typedef struct packed {
		logic        req_type;
		logic [7:0]  rx_byte;
		logic [15:0] motor_word;
		logic [15:0] servo_word;
	} req_t;

	typedef struct packed {
		logic [1:0]         out_kind;
		logic signed [15:0] left_speed;
		logic signed [15:0] right_speed;
		logic               ack_ok;
		logic               ready_flag;
		logic [7:0]         tx_byte;
		logic               last;
	} res_t;

	// One finished frame handed from the front to the back.
	// cmd_body[0] is frame byte 1 (motor high) and cmd_body[4] the sum.
	typedef struct packed {
		logic                        csum_err;
		logic                        with_cmd;
		logic signed [15:0]          left_speed;
		logic signed [15:0]          right_speed;
		logic                        ack_ok;
		logic                        ready_flag;
		logic [BODY_BYTES-1:0][7:0]  cmd_body;
	} job_t;

	// Write side of the job queue.
	typedef struct packed {
		logic push;
		job_t job;
	} job_wr_t;

	// Read side of the job queue.
	typedef struct packed {
		logic valid;
		logic full;
		job_t job;
	} job_rd_t;

endpackage

[rtl/core/mlfh_stream_if.sv]
// Valid/ready channel carrying one payload beat per handshake.
// Depends on nothing; the payload type is given by the instantiating level.
interface mlfh_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[rtl/core/mlfh_front.sv]
// Front part: accepts request beats, deframes link bytes and keeps the
// pending command frame. Depends on mlfh_pkg and mlfh_stream_if.
module mlfh_front import mlfh_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	mlfh_stream_if.sink   req,
	input  logic          q_full,
	output job_wr_t       wr
);

	logic [POS_W-1:0]           pos_q;
	logic [BODY_BYTES-1:0][7:0] body_q;
	logic [BODY_BYTES-1:0][7:0] cmd_q;
	logic                       pend_q;

	logic       accept;
	logic [7:0] rx_sum;
	logic [7:0] cmd_sum;
	logic       at_end;
	logic       bad_sum;

	// A beat is taken whenever the queue can hold a job.
	assign req.ready = !q_full;
	assign accept    = req.valid && req.ready;

	// Sum of the four speed bytes and of the four command bytes.
	assign rx_sum  = body_q[3] + body_q[2] + body_q[1] + body_q[0];
	assign cmd_sum = req.payload.motor_word[15:8] + req.payload.motor_word[7:0]
		+ req.payload.servo_word[15:8] + req.payload.servo_word[7:0];

	assign at_end  = (pos_q == POS_W'(FRAME_BYTES - 1));
	assign bad_sum = (rx_sum != req.payload.rx_byte);

	// Job for a completed frame.
	always_comb begin
		wr.push            = accept && (req.payload.req_type == REQ_RX_BYTE) && at_end;
		wr.job.csum_err    = bad_sum;
		wr.job.with_cmd    = pend_q && !bad_sum;
		wr.job.left_speed  = $signed({body_q[3], body_q[2]});
		wr.job.right_speed = $signed({body_q[1], body_q[0]});
		wr.job.ack_ok      = (body_q[4][7:4] == NIBBLE_SET);
		wr.job.ready_flag  = (body_q[4][3:0] == NIBBLE_SET);
		wr.job.cmd_body    = cmd_q;
	end

	// Deframer position and pending command flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			pend_q <= 1'b0;
		end else if (accept) begin
			if (req.payload.req_type == REQ_COMMAND) begin
				pend_q <= 1'b1;
			end else if (pos_q == '0) begin
				if (req.payload.rx_byte == SYNC_BYTE) begin
					pos_q <= POS_W'(1);
				end
			end else if (!at_end) begin
				pos_q <= pos_q + POS_W'(1);
			end else begin
				pos_q <= '0;
				if (!bad_sum) begin
					pend_q <= 1'b0;
				end
			end
		end
	end

	// Received frame body: bytes shift in, byte 1 ends up at the top.
	always_ff @(posedge clk) begin
		if (accept && (req.payload.req_type == REQ_RX_BYTE) && (pos_q != '0) && !at_end) begin
			body_q <= {body_q[BODY_BYTES-2:0], req.payload.rx_byte};
		end
	end

	// Pending command frame body.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= '0;
		end else if (accept && (req.payload.req_type == REQ_COMMAND)) begin
			cmd_q[0] <= req.payload.motor_word[15:8];
			cmd_q[1] <= req.payload.motor_word[7:0];
			cmd_q[2] <= req.payload.servo_word[15:8];
			cmd_q[3] <= req.payload.servo_word[7:0];
			cmd_q[4] <= cmd_sum;
		end
	end

endmodule

[rtl/core/mlfh_queue.sv]
// Short job queue between the front and the back parts.
// Depends on mlfh_pkg.
module mlfh_queue import mlfh_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic    clk,
	input  logic    arst_n,
	input  job_wr_t wr,
	input  logic    pop,
	output job_rd_t rd
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign rd.valid = (cnt_q != '0);
	assign rd.full  = (cnt_q == CNT_W'(DEPTH));
	assign rd.job   = mem_q[rd_ptr_q];

	// Storage.
	always_ff @(posedge clk) begin
		if (wr.push) begin
			mem_q[wr_ptr_q] <= wr.job;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr.push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (wr.push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !wr.push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/core/mlfh_back.sv]
// Back part: turns each queued job into its result beats, one per cycle while
// res.ready allows, through an output register. Depends on mlfh_pkg, mlfh_stream_if.
module mlfh_back import mlfh_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  job_rd_t        rd,
	output logic           pop,
	mlfh_stream_if.source  res
);

	logic [STEP_W-1:0] step_q;
	logic              valid_q;
	res_t              res_q;

	logic              load;
	logic              is_last;
	res_t              next_res;

	assign res.valid   = valid_q;
	assign res.payload = res_q;

	// The output register takes a new beat when empty or being emptied.
	assign load = rd.valid && (!valid_q || res.ready);
	assign pop  = load && is_last;

	// Result for the current step of the head job.
	always_comb begin
		next_res = '0;
		is_last  = 1'b0;
		if (step_q == '0) begin
			is_last = rd.job.csum_err || !rd.job.with_cmd;
			if (rd.job.csum_err) begin
				next_res.out_kind = KIND_CSUM_ERR;
			end else begin
				next_res.out_kind    = KIND_SPEED;
				next_res.left_speed  = rd.job.left_speed;
				next_res.right_speed = rd.job.right_speed;
				next_res.ack_ok      = rd.job.ack_ok;
				next_res.ready_flag  = rd.job.ready_flag;
			end
		end else begin
			next_res.out_kind = KIND_TX;
			is_last           = (step_q == STEP_W'(FRAME_BYTES));
			if (step_q == STEP_W'(1)) begin
				next_res.tx_byte = TX_HEAD;
			end else if (step_q == STEP_W'(FRAME_BYTES)) begin
				next_res.tx_byte = TX_TAIL;
			end else begin
				next_res.tx_byte = rd.job.cmd_body[step_q - STEP_W'(2)];
			end
		end
		next_res.last = is_last;
	end

	// Step counter and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			step_q  <= is_last ? '0 : step_q + STEP_W'(1);
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= next_res;
		end
	end

endmodule

[rtl/core/motor_link_frame_handler_top.sv]
// Top level of the motor link frame handler: front, job queue and back.
// Depends on mlfh_pkg, mlfh_stream_if, mlfh_front, mlfh_queue and mlfh_back.
//
// Channels: req carries request beats (a received link byte or a new motor
// and servo command); res carries result beats (speed report, checksum error
// or command byte to transmit), with last set on the final beat of a frame.
// A beat moves when valid and ready are both high at a rising edge of clk.
//
// Throughput: one request beat per cycle while the queue is not full. The
// front deframes and classifies each byte in the cycle it arrives; a
// completed frame becomes a job in a queue of QUEUE_DEPTH entries. The back
// delivers one result beat per cycle while the receiver is ready; a frame
// with a pending command gives eight result beats. The first result beat of
// a frame passes through the queue and then the output register.
//
// When the receiver stalls, the output register holds its beat and the
// queue fills; req.ready falls only when the queue is full. Asynchronous
// reset (arst_n low) empties the queue and the output register, returns the
// deframer to idle and clears the pending command.
module motor_link_frame_handler_top import mlfh_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	mlfh_stream_if.sink   req,
	mlfh_stream_if.source res
);

	job_wr_t wr;
	job_rd_t rd;
	logic    pop;

	mlfh_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.q_full (rd.full),
		.wr     (wr)
	);

	mlfh_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.pop    (pop),
		.rd     (rd)
	);

	mlfh_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.pop    (pop),
		.res    (res)
	);

	// The front never pushes into a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		wr.push |-> !rd.full)
		else $error("job pushed into a full queue");

	// The back only pops a job that is present.
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> rd.valid)
		else $error("job popped from an empty queue");

	// A checksum error is always a frame's only result.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.payload.out_kind == KIND_CSUM_ERR)) |-> res.payload.last)
		else $error("checksum error not marked last");

	// The last transmit beat is the frame tail.
	a_tx_tail: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.payload.out_kind == KIND_TX) && res.payload.last)
			|-> (res.payload.tx_byte == TX_TAIL))
		else $error("last transmit beat is not the tail byte");

endmodule

[tb/sv/tb_motor_link_frame_handler_top.sv]
// Self-checking testbench for the motor link frame handler top level.
// Depends on mlfh_pkg, mlfh_stream_if and motor_link_frame_handler_top.
// It predicts every result beat and compares it field by field as it leaves.
module tb_motor_link_frame_handler_top;
	import mlfh_pkg::*;

	localparam int CLK_PERIOD       = 10;
	localparam int MAX_GAP          = 19;
	localparam int RANDOM_ITEMS     = 125;
	localparam int LONG_HOLD_CYCLES = 150;
	localparam int DRAIN_CYCLES     = 20;
	localparam int RUN_LIMIT        = 3_000_000;

	logic clk;
	logic arst_n;

	mlfh_stream_if #(.payload_t(req_t)) req_if ();
	mlfh_stream_if #(.payload_t(res_t)) res_if ();

	motor_link_frame_handler_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.res    (res_if)
	);

	// Predicted state of the deframer and the pending command.
	bit   [2:0] rx_count;
	logic [7:0] rx_held [FRAME_BYTES-1];
	logic [7:0] cmd_frame [FRAME_BYTES];
	bit         cmd_waiting;

	// Result beats still owed by the block, oldest first.
	res_t link_results_due [$];

	int error_count;
	int counted_items;
	bit req_gaps_on;
	bit res_gaps_on;
	bit long_hold_due;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Hard limit on the length of the run.
	initial begin
		#(RUN_LIMIT);
		$display("FAILURE");
		$finish;
	end

	function automatic res_t make_result(logic [1:0] kind, logic [15:0] left, logic [15:0] right,
			logic ack, logic rdy, logic [7:0] txb);
		res_t x;
		x.out_kind    = kind;
		x.left_speed  = left;
		x.right_speed = right;
		x.ack_ok      = ack;
		x.ready_flag  = rdy;
		x.tx_byte     = txb;
		x.last        = 1'b0;
		return x;
	endfunction

	// Updates the predicted state for one accepted request and queues the beats it causes.
	// Returns zero when the byte is simply dropped by an idle deframer.
	function automatic bit predict_request(req_t r);
		res_t       beats [$];
		logic [7:0] sum;
		if (r.req_type == REQ_COMMAND) begin
			cmd_frame[1] = r.motor_word[15:8];
			cmd_frame[2] = r.motor_word[7:0];
			cmd_frame[3] = r.servo_word[15:8];
			cmd_frame[4] = r.servo_word[7:0];
			cmd_frame[5] = cmd_frame[1] + cmd_frame[2] + cmd_frame[3] + cmd_frame[4];
			cmd_waiting = 1'b1;
			return 1'b1;
		end
		if (rx_count == 0) begin
			if (r.rx_byte == SYNC_BYTE) begin
				rx_held[0] = r.rx_byte;
				rx_count = 3'd1;
				return 1'b1;
			end
			return 1'b0;
		end
		if (rx_count < FRAME_BYTES - 1) begin
			rx_held[rx_count] = r.rx_byte;
			rx_count = rx_count + 3'd1;
			return 1'b1;
		end

		// Final byte of the frame carries the checksum.
		rx_count = '0;
		sum = rx_held[2] + rx_held[3] + rx_held[4] + rx_held[5];
		if (sum != r.rx_byte) begin
			beats.push_back(make_result(KIND_CSUM_ERR, '0, '0, 1'b0, 1'b0, '0));
		end else begin
			beats.push_back(make_result(KIND_SPEED, {rx_held[2], rx_held[3]},
				{rx_held[4], rx_held[5]}, rx_held[1][7:4] == NIBBLE_SET,
				rx_held[1][3:0] == NIBBLE_SET, '0));
			if (cmd_waiting) begin
				cmd_waiting = 1'b0;
				foreach (cmd_frame[i])
					beats.push_back(make_result(KIND_TX, '0, '0, 1'b0, 1'b0, cmd_frame[i]));
			end
		end
		beats[beats.size() - 1].last = 1'b1;
		foreach (beats[i])
			link_results_due.push_back(beats[i]);
		return 1'b1;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// Offers one request beat, after a random gap if req_gaps_on is set, and waits until it is taken.
	task automatic send_request(req_t r);
		int gap;
		gap = req_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= r;
		do @(posedge clk); while (!req_if.ready);
		void'(predict_request(r));
		counted_items++;
		@(negedge clk);
	endtask

	// Unused fields carry random values, since the block must ignore them.
	task automatic send_byte(logic [7:0] b);
		req_t r;
		r.req_type   = REQ_RX_BYTE;
		r.rx_byte    = b;
		r.motor_word = 16'($urandom);
		r.servo_word = 16'($urandom);
		send_request(r);
	endtask

	task automatic send_command(logic [15:0] motor, logic [15:0] servo);
		req_t r;
		r.req_type   = REQ_COMMAND;
		r.rx_byte    = 8'($urandom);
		r.motor_word = motor;
		r.servo_word = servo;
		send_request(r);
	endtask

	// Sends a complete frame; a corrupt frame gets a checksum that cannot match.
	task automatic send_frame(logic [7:0] flags, logic [15:0] left, logic [15:0] right,
			bit corrupt);
		logic [7:0] sum;
		sum = left[15:8] + left[7:0] + right[15:8] + right[7:0];
		if (corrupt)
			sum = sum ^ 8'($urandom_range(1, 255));
		send_byte(SYNC_BYTE);
		send_byte(flags);
		send_byte(left[15:8]);
		send_byte(left[7:0]);
		send_byte(right[15:8]);
		send_byte(right[7:0]);
		send_byte(sum);
	endtask

	function automatic logic [7:0] pick_flags();
		case ($urandom_range(0, 3))
			0: begin
				return 8'hFF;
			end
			1: begin
				return 8'hF0;
			end
			2: begin
				return 8'h0F;
			end
			default: begin
				return 8'($urandom);
			end
		endcase
	endfunction

	// Bytes outside a frame must be dropped without any result.
	task automatic test_idle_noise();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SYNC_BYTE + 8'd1);
	endtask

	// A good frame with nothing pending gives a lone speed report, extreme speeds.
	task automatic test_report_only();
		send_frame(8'hFF, 16'h8000, 16'h7FFF, 1'b0);
	endtask

	// A bad checksum gives an error and leaves the pending command in place.
	task automatic test_bad_checksum_keeps_command();
		send_command(16'hFFFF, 16'h0000);
		send_frame(8'h0F, 16'hFFFF, 16'h0000, 1'b1);
	endtask

	// A command arriving mid-frame replaces the pending one and leaves the frame intact.
	task automatic test_command_mid_frame();
		send_byte(SYNC_BYTE);
		send_byte(8'hF0);
		send_byte(8'h12);
		send_byte(8'h34);
		send_command(16'h0000, 16'hFFFF);
		send_byte(8'hFE);
		send_byte(8'hDC);
		send_byte(8'h12 + 8'h34 + 8'hFE + 8'hDC);
	endtask

	// Mostly well-formed frames with random content, plus commands, noise and cut frames.
	task automatic test_random_traffic();
		int target;
		int cut;
		target = counted_items + RANDOM_ITEMS;
		while (counted_items < target) begin
			if ($urandom_range(0, 39) == 0) begin
				req_gaps_on = 1'($urandom_range(0, 1));
				res_gaps_on = 1'($urandom_range(0, 1));
			end
			case ($urandom_range(0, 9))
				0, 1: begin
					send_command(16'($urandom), 16'($urandom));
				end
				2: begin
					send_byte(8'($urandom));
				end
				3: begin
					cut = $urandom_range(1, 5);
					send_byte(SYNC_BYTE);
					repeat (cut - 1) send_byte(8'($urandom));
				end
				default: begin
					send_frame(pick_flags(), 16'($urandom), 16'($urandom),
						$urandom_range(0, 4) == 0);
				end
			endcase
		end
		req_gaps_on = 1'b1;
		res_gaps_on = 1'b1;
	endtask

	// The receiver holds off for a long stretch while frames with commands keep coming.
	task automatic test_output_backpressure();
		req_gaps_on   = 1'b0;
		long_hold_due = 1'b1;
		repeat (6) begin
			send_command(16'($urandom), 16'($urandom));
			send_frame(pick_flags(), 16'($urandom), 16'($urandom), 1'b0);
		end
		req_gaps_on = 1'b1;
	endtask

	// Receiver: stalls before each beat for a random gap while res_gaps_on is set.
	initial begin
		int stall;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold_due) begin
				long_hold_due = 1'b0;
				res_if.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
			end
			stall = res_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	// Each accepted result beat is compared with the oldest prediction.
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got = res_if.payload;
			if (link_results_due.size() == 0) begin
				report_mismatch("unexpected beat", got[31:0], '0);
			end else begin
				want = link_results_due.pop_front();
				if (got.out_kind !== want.out_kind)
					report_mismatch("out_kind", 32'(got.out_kind), 32'(want.out_kind));
				if (got.left_speed !== want.left_speed)
					report_mismatch("left_speed", 32'(got.left_speed),
						32'(want.left_speed));
				if (got.right_speed !== want.right_speed)
					report_mismatch("right_speed", 32'(got.right_speed),
						32'(want.right_speed));
				if (got.ack_ok !== want.ack_ok)
					report_mismatch("ack_ok", 32'(got.ack_ok), 32'(want.ack_ok));
				if (got.ready_flag !== want.ready_flag)
					report_mismatch("ready_flag", 32'(got.ready_flag),
						32'(want.ready_flag));
				if (got.tx_byte !== want.tx_byte)
					report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
				if (got.last !== want.last)
					report_mismatch("last", 32'(got.last), 32'(want.last));
			end
		end
	end

	// Reset, the tests in turn, then the drain and the verdict.
	initial begin
		arst_n          = 1'b0;
		req_if.valid    = 1'b0;
		req_if.payload  = '0;
		error_count     = 0;
		counted_items   = 0;
		req_gaps_on     = 1'b1;
		res_gaps_on     = 1'b1;
		long_hold_due   = 1'b0;
		rx_count        = '0;
		cmd_waiting     = 1'b0;
		foreach (cmd_frame[i])
			cmd_frame[i] = 8'h00;
		cmd_frame[0]             = TX_HEAD;
		cmd_frame[FRAME_BYTES-1] = TX_TAIL;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_noise();
		test_report_only();
		test_bad_checksum_keeps_command();
		test_command_mid_frame();
		test_random_traffic();
		test_output_backpressure();

		req_if.valid <= 1'b0;
		while (link_results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
